>>> hw/rtl/ecas_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the arctangent table for the commutation angle core.
// No dependencies; every other file refers to this package by scoped names.
package ecas_pkg;

    localparam int PHASE_BITS_DEF    = 32;
    localparam int OUT_BITS_DEF      = 16;
    localparam int CORDIC_STAGES_DEF = 16;

    // Number of arctangent entries available; stages beyond this are not built.
    localparam int ATAN_LEN = 24;

    // Width of the rotation datapath: x and y on a 2^30 scale, z as a turn fraction.
    localparam int CW = 34;

    // Start value of x: the rotation gain compensation K times 2^30.
    localparam logic signed [CW-1:0] GAIN_START = 34'sd652032874;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 neg;
        logic [15:0]          angle;
    } cordic_t;

    // atan(2^-i) / (2*pi) * 2^32, rounded.
    function automatic logic [31:0] atan_entry(input logic [4:0] idx);
        logic [31:0] val;
        case (idx)
            5'd0:    val = 32'd536870912;
            5'd1:    val = 32'd316933406;
            5'd2:    val = 32'd167458907;
            5'd3:    val = 32'd85004756;
            5'd4:    val = 32'd42667331;
            5'd5:    val = 32'd21354465;
            5'd6:    val = 32'd10680862;
            5'd7:    val = 32'd5340245;
            5'd8:    val = 32'd2670163;
            5'd9:    val = 32'd1335087;
            5'd10:   val = 32'd667544;
            5'd11:   val = 32'd333772;
            5'd12:   val = 32'd166886;
            5'd13:   val = 32'd83443;
            5'd14:   val = 32'd41722;
            5'd15:   val = 32'd20861;
            5'd16:   val = 32'd10430;
            5'd17:   val = 32'd5215;
            5'd18:   val = 32'd2608;
            5'd19:   val = 32'd1304;
            5'd20:   val = 32'd652;
            5'd21:   val = 32'd326;
            5'd22:   val = 32'd163;
            5'd23:   val = 32'd81;
            default: val = 32'd0;
        endcase
        return val;
    endfunction

endpackage

>>> hw/rtl/ecas_phase.sv
`timescale 1ns / 1ps
// Phase front end: position difference, scaling by the phase step, accumulation.
// Depends on ecas_pkg only for the default phase width; three registered stages.
module ecas_phase #(
    parameter int PHASE_BITS = ecas_pkg::PHASE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [31:0]           cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [31:0]           position,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [PHASE_BITS-1:0] phase
);

    logic [31:0]           phase_step_reg;
    logic [31:0]           last_position_reg;
    logic [31:0]           diff_reg;
    logic [PHASE_BITS-1:0] prod_reg;
    logic [PHASE_BITS-1:0] phase_reg;
    logic                  v1_reg, v2_reg, v3_reg;
    logic                  r1, r2, r3;
    logic signed [64:0]    prod_full;

    assign cfg_ready = 1'b1;

    assign r3       = !v3_reg || out_ready;
    assign r2       = !v2_reg || r3;
    assign r1       = !v1_reg || r2;
    assign in_ready = r1;

    // The count step is signed; the phase step is unsigned, hence the zero bit.
    assign prod_full = $signed(diff_reg) * $signed({1'b0, phase_step_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg    <= '0;
            last_position_reg <= '0;
            phase_reg         <= '0;
            v1_reg            <= 1'b0;
            v2_reg            <= 1'b0;
            v3_reg            <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                phase_step_reg <= cfg_data;
            end
            if (r1)
            begin
                v1_reg <= in_valid;
            end
            if (in_valid && r1)
            begin
                last_position_reg <= position;
            end
            if (r2)
            begin
                v2_reg <= v1_reg;
            end
            if (r3)
            begin
                v3_reg <= v2_reg;
            end
            if (v2_reg && r3)
            begin
                phase_reg <= phase_reg + prod_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && r1)
        begin
            diff_reg <= position - last_position_reg;
        end
        if (v1_reg && r2)
        begin
            prod_reg <= prod_full[PHASE_BITS-1:0];
        end
    end

    assign out_valid = v3_reg;
    assign phase     = phase_reg;

endmodule

>>> hw/rtl/ecas_cell.sv
`timescale 1ns / 1ps
// One rotation cell of the sine/cosine chain, holding one item in flight.
// Depends on ecas_pkg for the item type and the arctangent table.
module ecas_cell #(
    parameter int IDX = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ecas_pkg::cordic_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output ecas_pkg::cordic_t out_data
);

    localparam logic signed [ecas_pkg::CW-1:0] ATAN =
        $signed(ecas_pkg::CW'(ecas_pkg::atan_entry(5'(IDX))));

    logic              valid_reg;
    ecas_pkg::cordic_t data_reg;
    ecas_pkg::cordic_t data_next;
    logic signed [ecas_pkg::CW-1:0] dx, dy;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        dx        = in_data.y >>> IDX;
        dy        = in_data.x >>> IDX;
        data_next = in_data;
        if (!in_data.z[ecas_pkg::CW-1])
        begin
            data_next.x = in_data.x - dx;
            data_next.y = in_data.y + dy;
            data_next.z = in_data.z - ATAN;
        end
        else
        begin
            data_next.x = in_data.x + dx;
            data_next.y = in_data.y - dy;
            data_next.z = in_data.z + ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> hw/rtl/ecas_out.sv
`timescale 1ns / 1ps
// Output stage: rounds x and y, undoes the half-turn fold, saturates, registers.
// Depends on ecas_pkg for the item type.
module ecas_out #(
    parameter int OUT_BITS = ecas_pkg::OUT_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  ecas_pkg::cordic_t          in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [15:0]                angle,
    output logic signed [OUT_BITS-1:0] cosine,
    output logic signed [OUT_BITS-1:0] sine
);

    localparam int SH = 31 - OUT_BITS;
    localparam int RW = ecas_pkg::CW + 1;
    localparam logic signed [RW-1:0] RND = RW'(1) <<< (SH - 1);
    localparam logic signed [RW-1:0] HI  = (RW'(1) <<< (OUT_BITS - 1)) - RW'(1);
    localparam logic signed [RW-1:0] LO  = -(RW'(1) <<< (OUT_BITS - 1));

    logic                       valid_reg;
    logic [15:0]                angle_reg;
    logic signed [OUT_BITS-1:0] cos_reg, sin_reg;

    function automatic logic signed [OUT_BITS-1:0] finish(
        input logic signed [ecas_pkg::CW-1:0] v,
        input logic                           neg
    );
        logic signed [RW-1:0] r;
        logic signed [RW-1:0] s;
        r = (RW'(v) + RND) >>> SH;
        s = neg ? -r : r;
        if (s > HI)
        begin
            s = HI;
        end
        else if (s < LO)
        begin
            s = LO;
        end
        return s[OUT_BITS-1:0];
    endfunction

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            angle_reg <= in_data.angle;
            cos_reg   <= finish(in_data.x, in_data.neg);
            sin_reg   <= finish(in_data.y, in_data.neg);
        end
    end

    assign out_valid = valid_reg;
    assign angle     = angle_reg;
    assign cosine    = cos_reg;
    assign sine      = sin_reg;

endmodule

>>> hw/rtl/encoder_commutation_angle_sin_cos_core.sv
`timescale 1ns / 1ps
// Encoder commutation angle with sine and cosine, top level.
// An accepted input transaction passes the phase front end, the rotation cells and
// the output register. Throughput: one transaction per cycle unless m_tready stalls it.
// Reset (rst_n, asynchronous, active low) clears the phase step, last position,
// phase accumulator and all stage valid bits.
module encoder_commutation_angle_sin_cos_core #(
    parameter int PHASE_BITS    = ecas_pkg::PHASE_BITS_DEF,
    parameter int OUT_BITS      = ecas_pkg::OUT_BITS_DEF,
    parameter int CORDIC_STAGES = ecas_pkg::CORDIC_STAGES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write channel: phase step per encoder count.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    // Input stream. s_tdata: [31:0] position.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    // Output stream. m_tdata: angle (16 bits), cosine (OUT_BITS), sine (OUT_BITS),
    // then zero padding to whole bytes.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [((16 + 2 * OUT_BITS + 7) / 8) * 8 - 1:0] m_tdata
);

    // The chain stops at the end of the arctangent table.
    localparam int NST = (CORDIC_STAGES < ecas_pkg::ATAN_LEN) ?
                         CORDIC_STAGES : ecas_pkg::ATAN_LEN;
    localparam int DW  = ((16 + 2 * OUT_BITS + 7) / 8) * 8;
    localparam int PAD = DW - (16 + 2 * OUT_BITS);

    logic                       ph_valid;
    logic [PHASE_BITS-1:0]      phase;
    logic [31:0]                turn;
    logic [31:0]                turn_folded;
    logic                       fold;

    logic [NST:0]               stage_valid;
    logic [NST:0]               stage_ready;
    ecas_pkg::cordic_t          stage_data [0:NST];

    logic [15:0]                angle;
    logic signed [OUT_BITS-1:0] cosine;
    logic signed [OUT_BITS-1:0] sine;

    // Front end: the count difference wraps modulo 2^32 and is read as signed;
    // the scaled step is added to the phase modulo 2^PHASE_BITS.
    ecas_phase #(
        .PHASE_BITS (PHASE_BITS)
    ) u_phase (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .position  (s_tdata[31:0]),
        .out_valid (ph_valid),
        .out_ready (stage_ready[0]),
        .phase     (phase)
    );

    // Align the phase to a 32-bit turn fraction.
    generate
        if (PHASE_BITS >= 32)
        begin : g_align_drop
            assign turn = phase[PHASE_BITS-1 -: 32];
        end
        else
        begin : g_align_pad
            assign turn = {phase, {(32 - PHASE_BITS){1'b0}}};
        end
    endgenerate

    // The rotation converges only within a quarter turn either side of zero.
    // Angles in the second and third quadrants are turned by half a turn and
    // the results negated at the end.
    assign fold        = turn[31] ^ turn[30];
    assign turn_folded = {turn[31] ^ fold, turn[30:0]};

    always_comb
    begin
        stage_data[0].x     = ecas_pkg::GAIN_START;
        stage_data[0].y     = '0;
        stage_data[0].z     = ecas_pkg::CW'($signed(turn_folded));
        stage_data[0].neg   = fold;
        stage_data[0].angle = phase[PHASE_BITS-1 -: 16];
    end
    assign stage_valid[0] = ph_valid;

    // Row of rotation cells; each one holds one transaction and passes it on.
    generate
        for (genvar i = 0; i < NST; i++)
        begin : g_cell
            ecas_cell #(
                .IDX (i)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (stage_valid[i]),
                .in_ready  (stage_ready[i]),
                .in_data   (stage_data[i]),
                .out_valid (stage_valid[i+1]),
                .out_ready (stage_ready[i+1]),
                .out_data  (stage_data[i+1])
            );
        end
    endgenerate

    // Rounding, unfold and saturation into the output register.
    ecas_out #(
        .OUT_BITS (OUT_BITS)
    ) u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stage_valid[NST]),
        .in_ready  (stage_ready[NST]),
        .in_data   (stage_data[NST]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .angle     (angle),
        .cosine    (cosine),
        .sine      (sine)
    );

    generate
        if (PAD > 0)
        begin : g_pad
            assign m_tdata = {{PAD{1'b0}}, sine, cosine, angle};
        end
        else
        begin : g_nopad
            assign m_tdata = {sine, cosine, angle};
        end
    endgenerate

    // With the output register empty, every stage can move, so the input
    // must be ready.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input not ready while output register is empty");

    // After the quadrant fold the start angle lies within a quarter turn of zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid[0] |->
            (stage_data[0].z[ecas_pkg::CW-1:30] == '0) ||
            (stage_data[0].z[ecas_pkg::CW-1:30] == '1))
        else $error("folded start angle outside a quarter turn");

    // The first cell, when it holds a transaction and is not drained, keeps it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid[1] && !stage_ready[1]) |=> stage_valid[1])
        else $error("first cell dropped a stalled transaction");

endmodule
